### design/dtc_pkg.sv
// Shared types and constants of the divider / counter timer.
`default_nettype none
package dtc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned NumSel   = 4;
  localparam int unsigned StepW    = 6;

  // request types
  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  // register offsets
  localparam logic [15:0] OFF_DIV = 16'd0;
  localparam logic [15:0] OFF_CNT = 16'd1;
  localparam logic [15:0] OFF_RLD = 16'd2;
  localparam logic [15:0] OFF_CTL = 16'd3;

  // register select on the core write path
  localparam logic [1:0] SEL_DIV = 2'd0;
  localparam logic [1:0] SEL_CNT = 2'd1;
  localparam logic [1:0] SEL_RLD = 2'd2;
  localparam logic [1:0] SEL_CTL = 2'd3;

  localparam logic [15:0] DIV_INC = 16'd4;
  localparam int unsigned CTL_EN_BIT = 2;

  localparam logic [CfgDataW-1:0] BIT_SEL_RST [NumSel] = '{4'd9, 4'd3, 4'd5, 4'd7};

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  // sequencer -> core
  typedef struct packed {
    logic       step;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [7:0] wr_data;
  } core_cmd_t;

  // core -> sequencer
  typedef struct packed {
    logic [7:0] div_hi;
    logic [7:0] cnt;
    logic [7:0] rld;
    logic [7:0] ctl;
    logic       irq;
  } core_view_t;

endpackage
`default_nettype wire

### design/dtc_if.sv
// Request and response channel interfaces of the timer.
`default_nettype none
interface dtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] reg_offset;
  logic [7:0]  write_data;
  logic [7:0]  cycle_count;

  modport source (output valid, req_type, reg_offset, write_data, cycle_count, input ready);
  modport sink   (input valid, req_type, reg_offset, write_data, cycle_count, output ready);
endinterface

interface dtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [5:0] irq_count;
  logic       unhandled;

  modport source (output valid, read_data, irq_count, unhandled, input ready);
  modport sink   (input valid, read_data, irq_count, unhandled, output ready);
endinterface
`default_nettype wire

### design/dtc_core.sv
// Timer state registers and the shared single-step unit.
`default_nettype none
module dtc_core import dtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  core_cmd_t           cmd_i,
  output core_view_t          view_o
);

  logic [CfgDataW-1:0] bit_sel_q [NumSel];
  logic [15:0] div_q, div_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  rld_q, rld_d;
  logic [7:0]  ctl_q, ctl_d;
  logic        lvl_q, lvl_d;
  logic        ovf_q, ovf_d;

  logic [15:0]         div_nx;
  logic [7:0]          cnt_rl;
  logic [CfgDataW-1:0] pos;
  logic                level;
  logic                fall;

  // one step: advance divider, apply pending reload, look for falling edge
  always_comb begin
    div_nx = div_q + DIV_INC;
    cnt_rl = ovf_q ? rld_q : cnt_q;
    pos    = bit_sel_q[ctl_q[1:0]];
    level  = div_nx[pos] & ctl_q[CTL_EN_BIT];
    fall   = lvl_q & ~level;

    div_d = div_q;
    cnt_d = cnt_q;
    rld_d = rld_q;
    ctl_d = ctl_q;
    lvl_d = lvl_q;
    ovf_d = ovf_q;

    if (cmd_i.step) begin
      div_d = div_nx;
      cnt_d = fall ? cnt_rl + 8'd1 : cnt_rl;
      ovf_d = fall & (cnt_rl == 8'hFF);
      lvl_d = level;
    end else if (cmd_i.wr_en) begin
      unique case (cmd_i.wr_sel)
        SEL_DIV: div_d = '0;
        SEL_CNT: cnt_d = cmd_i.wr_data;
        SEL_RLD: rld_d = cmd_i.wr_data;
        SEL_CTL: ctl_d = cmd_i.wr_data;
        default: div_d = div_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
      cnt_q <= '0;
      rld_q <= '0;
      ctl_q <= '0;
      lvl_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      div_q <= div_d;
      cnt_q <= cnt_d;
      rld_q <= rld_d;
      ctl_q <= ctl_d;
      lvl_q <= lvl_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_sel_q <= BIT_SEL_RST;
    end else if (cfg_we_i) begin
      bit_sel_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign view_o.div_hi = div_q[15:8];
  assign view_o.cnt    = cnt_q;
  assign view_o.rld    = rld_q;
  assign view_o.ctl    = ctl_q;
  assign view_o.irq    = cmd_i.step & ovf_q;

endmodule
`default_nettype wire

### design/dtc_seq.sv
// Request decode, step sequencer and response register.
`default_nettype none
module dtc_seq import dtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtc_req_if.sink   req_i,
  dtc_rsp_if.source rsp_o,
  input  core_view_t view_i,
  output core_cmd_t  cmd_o
);

  seq_state_e       state_q, state_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [StepW-1:0] irq_q, irq_d;
  logic [StepW-1:0] irq_sum;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       rd_q, rd_d;
  logic [StepW-1:0] irqc_q, irqc_d;
  logic             unh_q, unh_d;
  logic             accept;
  logic             known;

  assign req_i.ready = (state_q == ST_IDLE) & (~out_valid_q | rsp_o.ready);
  assign accept      = req_i.valid & req_i.ready;
  assign irq_sum     = irq_q + {{(StepW-1){1'b0}}, view_i.irq};
  assign known       = (req_i.reg_offset[15:2] == 14'd0);

  always_comb begin
    state_d     = state_q;
    steps_d     = steps_q;
    irq_d       = irq_q;
    out_valid_d = out_valid_q & ~rsp_o.ready;
    rd_d        = rd_q;
    irqc_d      = irqc_q;
    unh_d       = unh_q;
    cmd_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_d   = '0;
          irqc_d = '0;
          unh_d  = 1'b0;
          unique case (req_i.req_type)
            REQ_READ: begin
              out_valid_d = 1'b1;
              unique case (req_i.reg_offset)
                OFF_DIV: rd_d  = view_i.div_hi;
                OFF_CNT: rd_d  = view_i.cnt;
                OFF_RLD: rd_d  = view_i.rld;
                OFF_CTL: rd_d  = view_i.ctl;
                default: unh_d = 1'b1;
              endcase
            end
            REQ_WRITE: begin
              out_valid_d   = 1'b1;
              unh_d         = ~known;
              cmd_o.wr_en   = known;
              cmd_o.wr_sel  = req_i.reg_offset[1:0];
              cmd_o.wr_data = req_i.write_data;
            end
            REQ_ADVANCE: begin
              if (req_i.cycle_count[7:2] == '0) begin
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_RUN;
                steps_d = req_i.cycle_count[7:2];
                irq_d   = '0;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (steps_q == StepW'(1)) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          rd_d        = '0;
          irqc_d      = irq_sum;
          unh_d       = 1'b0;
        end else begin
          steps_d = steps_q - StepW'(1);
          irq_d   = irq_sum;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      steps_q     <= '0;
      irq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      steps_q     <= steps_d;
      irq_q       <= irq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    irqc_q <= irqc_d;
    unh_q  <= unh_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = rd_q;
  assign rsp_o.irq_count = irqc_q;
  assign rsp_o.unhandled = unh_q;

  a_run_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !out_valid_q && !req_i.ready)
    else $error("response register busy while stepping");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (steps_q != '0))
    else $error("step count zero while stepping");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && steps_q != StepW'(1)) |=>
      (state_q == ST_RUN && steps_q == $past(steps_q) - StepW'(1)))
    else $error("step count did not decrement");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !cmd_o.step && accept)
    else $error("register write outside an accepted request");

endmodule
`default_nettype wire

### design/divider_timer_counter.sv
// Top level of the divider / counter timer.
// A 16-bit divider advances 4 per timer step; an 8-bit counter counts falling
// edges of one divider bit, chosen by control bits 1..0 and gated by control
// bit 2, and on wrapping is reloaded from the reload byte one step later,
// which also raises an interrupt. Each request gives exactly one response.
// A read or write request (offsets 0..3: divider high byte, counter, reload,
// control) is answered the cycle after it is taken; a divider write clears
// all 16 bits. An advance request runs cycle_count/4 steps, one step per clock
// through the single step unit in dtc_core, and the request side stays
// not-ready while they run. A new request is taken only when the response
// register is empty or being emptied in the same cycle. The four watched bit
// positions are written through the configuration port (index 0..3, 4-bit
// data) and should only be changed while the block is idle.
`default_nettype none
module divider_timer_counter import dtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dtc_req_if.sink             req_i,
  dtc_rsp_if.source           rsp_o
);

  core_cmd_t  cmd;   // register write or one timer step
  core_view_t view;  // current register values and step interrupt

  // sequencer: decodes the request, runs the step loop, holds the response
  dtc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .view_i (view),
    .cmd_o  (cmd)
  );

  // timer registers and the shared step unit
  dtc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .view_o     (view)
  );

endmodule
`default_nettype wire

### verif/dtc_timer_checker.sv
// Response checker for the divider / counter timer: predicts and compares every response.
module dtc_timer_checker import dtc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dtc_req_if                  req_i,
  dtc_rsp_if                  rsp_i,
  output int unsigned         fail_count_o,
  output int unsigned         open_count_o,
  output int unsigned         reads_o,
  output int unsigned         writes_o,
  output int unsigned         advances_o,
  output int unsigned         irqs_o,
  output int unsigned         unknown_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] read_data;
    logic [5:0] irq_count;
    logic       unhandled;
  } tmr_rsp_t;

  // shadow of the timer
  logic [CfgDataW-1:0] bit_pos_q [NumSel];
  logic [15:0]         div_q;
  logic [7:0]          cnt_q;
  logic [7:0]          rld_q;
  logic [7:0]          ctl_q;
  logic                level_q;
  logic                ovf_q;

  tmr_rsp_t awaited_rsp_q [$];

  // one divider step; returns 1 when the delayed reload fires
  function automatic logic step_timer();
    logic irq;
    logic lvl;
    irq   = 1'b0;
    div_q = div_q + DIV_INC;
    if (ovf_q) begin
      ovf_q = 1'b0;
      cnt_q = rld_q;
      irq   = 1'b1;
    end
    lvl = div_q[bit_pos_q[ctl_q[1:0]]] & ctl_q[CTL_EN_BIT];
    if (level_q && !lvl) begin
      cnt_q = cnt_q + 8'd1;
      if (cnt_q == 8'd0) ovf_q = 1'b1;
    end
    level_q = lvl;
    return irq;
  endfunction

  function automatic tmr_rsp_t predict_timer_rsp(logic [1:0] kind, logic [15:0] off,
                                                 logic [7:0] data, logic [7:0] cycles);
    tmr_rsp_t r;
    r = '0;
    case (kind)
      REQ_READ: begin
        case (off)
          OFF_DIV: r.read_data = div_q[15:8];
          OFF_CNT: r.read_data = cnt_q;
          OFF_RLD: r.read_data = rld_q;
          OFF_CTL: r.read_data = ctl_q;
          default: r.unhandled = 1'b1;
        endcase
      end
      REQ_WRITE: begin
        case (off)
          OFF_DIV: div_q = '0;  // data ignored, level left alone
          OFF_CNT: cnt_q = data;
          OFF_RLD: rld_q = data;
          OFF_CTL: ctl_q = data;
          default: r.unhandled = 1'b1;
        endcase
      end
      REQ_ADVANCE: begin
        repeat (cycles[7:2]) r.irq_count = r.irq_count + 6'(step_timer());
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tmr_rsp_t want;
    tmr_rsp_t got;
    if (!rst_ni) begin
      bit_pos_q    = BIT_SEL_RST;
      div_q        = '0;
      cnt_q        = '0;
      rld_q        = '0;
      ctl_q        = '0;
      level_q      = 1'b0;
      ovf_q        = 1'b0;
      awaited_rsp_q.delete();
      fail_count_o = 0;
      open_count_o = 0;
      reads_o      = 0;
      writes_o     = 0;
      advances_o   = 0;
      irqs_o       = 0;
      unknown_o    = 0;
    end else begin
      if (cfg_we_i) bit_pos_q[cfg_idx_i] = cfg_data_i;
      if (req_i.valid && req_i.ready) begin
        want = predict_timer_rsp(req_i.req_type, req_i.reg_offset, req_i.write_data,
                                 req_i.cycle_count);
        awaited_rsp_q.push_back(want);
        reads_o    += (req_i.req_type == REQ_READ);
        writes_o   += (req_i.req_type == REQ_WRITE);
        advances_o += (req_i.req_type == REQ_ADVANCE);
        irqs_o     += want.irq_count;
        unknown_o  += want.unhandled;
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.read_data, rsp_i.irq_count, rsp_i.unhandled};
        if (awaited_rsp_q.size() == 0) begin
          $error("response with no request outstanding: read_data %0h irq_count %0d unhandled %0b",
                 got.read_data, got.irq_count, got.unhandled);
          fail_count_o++;
        end else begin
          want = awaited_rsp_q.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_count", 8'(want.irq_count), 8'(got.irq_count));
          check_field("unhandled", 8'(want.unhandled), 8'(got.unhandled));
        end
      end
      open_count_o = awaited_rsp_q.size();
    end
  end

endmodule

### verif/tb_divider_timer_counter.sv
// Testbench top for the divider / counter timer: clock, reset, stimulus and verdict.
module tb_divider_timer_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import dtc_pkg::*;

  // request type that the block answers with an all-zero response
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 240;
  localparam int unsigned WrapAdvances  = 288;   // enough max advances to wrap the divider
  localparam int unsigned BurstMax      = 40;
  localparam int unsigned GapMax        = 12;
  localparam int unsigned IdleLimit     = 5000;  // longest advance plus a long receiver stall
  localparam int unsigned TailCycles    = 70;    // one full advance and a response

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dtc_req_if req_ch ();
  dtc_rsp_if rsp_ch ();

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned n_reads;
  int unsigned n_writes;
  int unsigned n_advances;
  int unsigned n_irqs;
  int unsigned n_unknown;

  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_settings   = 1;  // reset values count as the first setting

  divider_timer_counter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  dtc_timer_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .open_count_o (open_count),
    .reads_o      (n_reads),
    .writes_o     (n_writes),
    .advances_o   (n_advances),
    .irqs_o       (n_irqs),
    .unknown_o    (n_unknown)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Response side back-pressure: a mode is held for a random stretch, then
  // another is drawn, so stalls land on every phase of an advance.
  rx_mode_e    rx_mode   = RX_ALWAYS;
  int unsigned rx_left   = 0;
  int unsigned rx_phase  = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_ALWAYS:   rsp_ch.ready <= 1'b1;
        RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 4) == 0);
        default:     rsp_ch.ready <= ((rx_phase % 7) < 3);
      endcase
    end
  end

  // Watchdog: counts cycles in which neither a request nor a response moved.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d responses outstanding",
               IdleLimit, open_count);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request. The sender runs in bursts; between bursts valid drops
  // for a random gap, and now and then a burst follows with no gap at all.
  // Called and returns at a rising edge; returns at the edge of acceptance.
  task automatic issue_request(input logic [1:0] kind, input logic [15:0] off,
                               input logic [7:0] data, input logic [7:0] cycles);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GapMax);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, BurstMax);
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.reg_offset  <= off;
    req_ch.write_data  <= data;
    req_ch.cycle_count <= cycles;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Holds the sender off until every outstanding response has been taken;
  // after that the block is idle. The count is looked at on the falling edge.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (open_count != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [1:0]          kind;
    logic [15:0]         off;
    logic [7:0]          data;
    logic [7:0]          cycles;
    logic [CfgDataW-1:0] pos;
    int unsigned         roll;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_READ;
    req_ch.reg_offset  = OFF_DIV;
    req_ch.write_data  = '0;
    req_ch.cycle_count = '0;
    rsp_ch.ready       = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part, reset bit positions ---
    // everything reads zero after reset
    issue_request(REQ_READ, OFF_DIV, 8'h00, 8'h00);
    issue_request(REQ_READ, OFF_CNT, 8'h00, 8'h00);
    issue_request(REQ_READ, OFF_RLD, 8'h00, 8'h00);
    issue_request(REQ_READ, OFF_CTL, 8'h00, 8'h00);
    // unknown offsets: read gives zero, write stores nothing, both flag it
    issue_request(REQ_READ, 16'hFFFF, 8'h00, 8'h00);
    issue_request(REQ_READ, OFF_CTL + 16'd1, 8'h00, 8'h00);
    issue_request(REQ_WRITE, 16'hFFFF, 8'hFF, 8'h00);
    issue_request(REQ_WRITE, 16'h8000, 8'h00, 8'h00);
    // unused request type with every field at its top
    issue_request(REQ_NOP, 16'hFFFF, 8'hFF, 8'hFF);
    // enable, clock select 1; counter one below wrap, reload near the top
    issue_request(REQ_WRITE, OFF_CTL, 8'h05, 8'h00);
    issue_request(REQ_WRITE, OFF_RLD, 8'hFE, 8'h00);
    issue_request(REQ_WRITE, OFF_CNT, 8'hFF, 8'h00);
    // fewer than four cycles: no step at all
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'h03);
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'h00);
    // longest advance: wraps, delayed reload and several interrupts
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'hFF);
    issue_request(REQ_READ, OFF_CNT, 8'h00, 8'h00);
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'hFF);
    issue_request(REQ_READ, OFF_DIV, 8'h00, 8'h00);
    // divider write clears it whatever the data
    issue_request(REQ_WRITE, OFF_DIV, 8'h5A, 8'h00);
    issue_request(REQ_READ, OFF_DIV, 8'h00, 8'h00);
    // spare control bits are stored and read back
    issue_request(REQ_WRITE, OFF_CTL, 8'hFF, 8'h00);
    issue_request(REQ_READ, OFF_CTL, 8'h00, 8'h00);
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'hFF);
    // dropping the enable may itself give a falling edge; remainder of two dropped
    issue_request(REQ_WRITE, OFF_CTL, 8'h00, 8'h00);
    issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'hFE);

    // --- random part, one bit-position setting per phase ---
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        // bit positions only change with the block idle
        drain_responses();
        for (int s = 0; s < NumSel; s++) begin
          case (phase)
            1:       pos = (s % 2 != 0) ? 4'd15 : 4'd0;
            2:       pos = (s % 2 != 0) ? 4'd0 : 4'd15;
            3:       pos = 4'(s + 2);   // bit 2 toggles on every step
            default: pos = 4'($urandom_range(0, 15));
          endcase
          cfg_we_i   <= 1'b1;
          cfg_idx_i  <= CfgIdxW'(s);
          cfg_data_i <= pos;
          @(posedge clk_i);
        end
        cfg_we_i <= 1'b0;
        n_settings++;
      end

      // top divider bit: clear, select it, then run long enough to wrap the
      // divider so that bit 15 both rises and falls
      if (phase == 1) begin
        issue_request(REQ_WRITE, OFF_DIV, 8'h00, 8'h00);
        issue_request(REQ_WRITE, OFF_CTL, 8'h05, 8'h00);
        for (int i = 0; i < WrapAdvances; i++) begin
          if (i % 16 == 15) issue_request(REQ_READ, OFF_CNT, 8'h00, 8'h00);
          else issue_request(REQ_ADVANCE, OFF_DIV, 8'h00, 8'($urandom_range(8'hFC, 8'hFF)));
        end
      end

      for (int i = 0; i < ItemsPerPhase; i++) begin
        roll   = $urandom_range(0, 99);
        off    = OFF_DIV + 16'($urandom_range(0, OFF_CTL));
        data   = 8'($urandom());
        cycles = 8'($urandom());
        if ($urandom_range(0, 15) == 0) off = 16'($urandom());
        if (roll < 40) begin
          kind = REQ_ADVANCE;
          // single steps make a counter write land on a pending reload
          if ($urandom_range(0, 3) == 0) cycles = 8'($urandom_range(4, 7));
        end else if (roll < 65) begin
          kind = REQ_READ;
        end else if (roll < 95) begin
          kind = REQ_WRITE;
          // keep divider clears rare so the higher bits get to move
          if (off == OFF_DIV && $urandom_range(0, 3) != 0) off = OFF_RLD;
          if (off == OFF_CTL && $urandom_range(0, 3) != 0) data[CTL_EN_BIT] = 1'b1;
          if (off == OFF_CNT && $urandom_range(0, 1) == 0) data = 8'($urandom_range(8'hF0, 8'hFF));
        end else begin
          kind = REQ_NOP;
        end
        issue_request(kind, off, data, cycles);
        // occasional full pause mid-phase
        if ($urandom_range(0, 99) == 0) drain_responses();
      end
    end

    drain_responses();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d reads, %0d writes and %0d advances under %0d bit-position settings;",
             n_reads, n_writes, n_advances, n_settings);
    $display("%0d timer interrupts and %0d unknown-offset accesses were predicted and checked.",
             n_irqs, n_unknown);
    if (fail_count == 0 && open_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### divider_timer_counter.f
design/dtc_pkg.sv
design/dtc_if.sv
design/dtc_core.sv
design/dtc_seq.sv
design/divider_timer_counter.sv
verif/dtc_timer_checker.sv
verif/tb_divider_timer_counter.sv
